// ===== hw/rtl/ntms_pkg.sv =====
package ntms_pkg;

  localparam int NB_N   = 16;
  localparam int TH_N   = 32;
  localparam int NB_AW  = (NB_N > 1) ? $clog2(NB_N) : 1;
  localparam int TH_AW  = (TH_N > 1) ? $clog2(TH_N) : 1;
  localparam int ADDR_W = 128;
  localparam int CNT_W  = $clog2(TH_N + 1);

  localparam logic [NB_AW-1:0] NB_LAST = NB_AW'(NB_N - 1);
  localparam logic [TH_AW-1:0] TH_LAST = TH_AW'(TH_N - 1);

  localparam logic [7:0] METRIC_ONE_HOP = 8'd1;
  localparam logic [7:0] METRIC_TWO_HOP = 8'd2;

  typedef enum logic [1:0] {
    KIND_ADD1 = 2'd0,
    KIND_ADD2 = 2'd1,
    KIND_DEL1 = 2'd2,
    KIND_DEL2 = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_METRIC    = 3'd1,
    ST_EXISTS        = 3'd2,
    ST_DEST_NEIGHBOR = 3'd3,
    ST_NO_NEXT_HOP   = 3'd4,
    ST_NOT_FOUND     = 3'd5,
    ST_FULL          = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_ADD1      = 3'd0,
    PH_DEL1      = 3'd1,
    PH_ADD2_DUP  = 3'd2,
    PH_ADD2_DEST = 3'd3,
    PH_ADD2_HOP  = 3'd4,
    PH_DEL2      = 3'd5
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_NB_RD,
    S_NB_CMP,
    S_TH_RD,
    S_TH_CMP,
    S_DECIDE,
    S_STATUS,
    S_OWN_N_RD,
    S_OWN_T_RD,
    S_OWN_T_CMP,
    S_CNT_CLR,
    S_CNT,
    S_PICK,
    S_RELAY_RD,
    S_RELAY_EMIT,
    S_FINISH
  } state_t;

endpackage

// ===== hw/rtl/neighbor_table_mpr_select_top.sv =====
// Neighbour table with greedy relay choice. Each input item adds or deletes a one-hop
// neighbour (16 slots) or a two-hop entry (32 slots); its run of results starts with
// the status and, when the change succeeds, goes on with one result per chosen relay,
// tlast on the final one. Items are handled one at a time. Neighbour and two-hop
// addresses sit in two memories with a registered read and separate read and write
// ports, so each table lookup reads a slot and then compares it. A successful
// item then maps every two-hop entry to its next-hop neighbour and runs up to 16
// relay rounds.
module neighbor_table_mpr_select_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // dest_hi, dest_lo, hop_hi, hop_lo, metric
  input  logic [263:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, relay_hi, relay_lo, zero pad
  output logic [135:0] m_tdata,
  // relay_valid
  output logic [0:0]   m_tuser,
  output logic         m_tlast
);

  localparam int NB_N  = ntms_pkg::NB_N;
  localparam int TH_N  = ntms_pkg::TH_N;
  localparam int NB_AW = ntms_pkg::NB_AW;
  localparam int TH_AW = ntms_pkg::TH_AW;
  localparam int AW    = ntms_pkg::ADDR_W;
  localparam int CW    = ntms_pkg::CNT_W;

  ntms_pkg::state_t  state, state_next;
  ntms_pkg::kind_t   kind_q;
  ntms_pkg::phase_t  phase;
  ntms_pkg::status_t status_q;

  logic [AW-1:0]    dest_q, hop_q;
  logic [7:0]       metric_q;
  logic [NB_AW-1:0] nb_idx, found_nb, best_idx;
  logic [TH_AW-1:0] th_idx, found_th;
  logic             found, best_ok;
  logic [CW-1:0]    best_cnt;

  logic [NB_N-1:0]  nb_valid, taken;
  logic [TH_N-1:0]  th_valid, covered, own_ok;
  logic [NB_AW-1:0] own [TH_N];
  logic [CW-1:0]    cnt [NB_N];

  // one result held back so that tlast can go on the final one
  logic              pend_valid, pend_rv;
  ntms_pkg::status_t pend_status;
  logic [AW-1:0]     pend_addr;

  logic              out_free;

  // memory ports
  logic             nb_we, nb_re, th_we, th_re;
  logic [NB_AW-1:0] nb_waddr, nb_raddr;
  logic [TH_AW-1:0] th_waddr, th_raddr;
  logic [AW-1:0]    nb_rd;
  logic [2*AW-1:0]  th_rd;

  logic [AW-1:0]    nb_key;
  logic             nb_hit, th_hit, own_hit;
  logic [NB_AW-1:0] nb_free;
  logic             nb_free_ok;
  logic [TH_AW-1:0] th_free;
  logic             th_free_ok;

  ntms_ram #(.WIDTH(AW), .DEPTH(NB_N)) u_nb_ram (
    .clk   (clk),
    .we    (nb_we),
    .waddr (nb_waddr),
    .wdata (dest_q),
    .re    (nb_re),
    .raddr (nb_raddr),
    .rdata (nb_rd)
  );

  // two-hop entry: destination low half, next hop high half
  ntms_ram #(.WIDTH(2 * AW), .DEPTH(TH_N)) u_th_ram (
    .clk   (clk),
    .we    (th_we),
    .waddr (th_waddr),
    .wdata ({hop_q, dest_q}),
    .re    (th_re),
    .raddr (th_raddr),
    .rdata (th_rd)
  );

  assign out_free = !m_tvalid || m_tready;
  assign nb_key   = (phase == ntms_pkg::PH_ADD2_HOP) ? hop_q : dest_q;
  assign nb_hit   = nb_valid[nb_idx] && (nb_rd == nb_key);
  assign th_hit   = th_valid[th_idx] && (th_rd[AW-1:0] == dest_q) &&
                    ((phase != ntms_pkg::PH_DEL2) || (th_rd[2*AW-1:AW] == hop_q));
  assign own_hit  = nb_valid[nb_idx] && (th_rd[2*AW-1:AW] == nb_rd);

  // lowest free slots
  always_comb begin
    nb_free    = '0;
    nb_free_ok = 1'b0;
    for (int i = NB_N - 1; i >= 0; i--) begin
      if (!nb_valid[i]) begin
        nb_free    = NB_AW'(i);
        nb_free_ok = 1'b1;
      end
    end
  end

  always_comb begin
    th_free    = '0;
    th_free_ok = 1'b0;
    for (int i = TH_N - 1; i >= 0; i--) begin
      if (!th_valid[i]) begin
        th_free    = TH_AW'(i);
        th_free_ok = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ntms_pkg::S_IDLE: begin
        if (s_tvalid) state_next = ntms_pkg::S_DISPATCH;
      end
      ntms_pkg::S_DISPATCH: begin
        unique case (kind_q)
          ntms_pkg::KIND_ADD1:
            state_next = (metric_q != ntms_pkg::METRIC_ONE_HOP) ?
                         ntms_pkg::S_STATUS : ntms_pkg::S_NB_RD;
          ntms_pkg::KIND_ADD2:
            state_next = (metric_q != ntms_pkg::METRIC_TWO_HOP) ?
                         ntms_pkg::S_STATUS : ntms_pkg::S_TH_RD;
          ntms_pkg::KIND_DEL1: state_next = ntms_pkg::S_NB_RD;
          ntms_pkg::KIND_DEL2: state_next = ntms_pkg::S_TH_RD;
          default:             state_next = ntms_pkg::S_STATUS;
        endcase
      end
      ntms_pkg::S_NB_RD: state_next = ntms_pkg::S_NB_CMP;
      ntms_pkg::S_NB_CMP: begin
        state_next = (nb_hit || nb_idx == ntms_pkg::NB_LAST) ?
                     ntms_pkg::S_DECIDE : ntms_pkg::S_NB_RD;
      end
      ntms_pkg::S_TH_RD: state_next = ntms_pkg::S_TH_CMP;
      ntms_pkg::S_TH_CMP: begin
        state_next = (th_hit || th_idx == ntms_pkg::TH_LAST) ?
                     ntms_pkg::S_DECIDE : ntms_pkg::S_TH_RD;
      end
      ntms_pkg::S_DECIDE: begin
        state_next = ntms_pkg::S_STATUS;
        if ((phase == ntms_pkg::PH_ADD2_DUP || phase == ntms_pkg::PH_ADD2_DEST) && !found)
          state_next = ntms_pkg::S_NB_RD;
      end
      ntms_pkg::S_STATUS: begin
        state_next = (status_q == ntms_pkg::ST_OK) ? ntms_pkg::S_OWN_N_RD :
                     ntms_pkg::S_FINISH;
      end
      ntms_pkg::S_OWN_N_RD: state_next = ntms_pkg::S_OWN_T_RD;
      ntms_pkg::S_OWN_T_RD: state_next = ntms_pkg::S_OWN_T_CMP;
      ntms_pkg::S_OWN_T_CMP: begin
        if (th_idx != ntms_pkg::TH_LAST)      state_next = ntms_pkg::S_OWN_T_RD;
        else if (nb_idx != ntms_pkg::NB_LAST) state_next = ntms_pkg::S_OWN_N_RD;
        else                                  state_next = ntms_pkg::S_CNT_CLR;
      end
      ntms_pkg::S_CNT_CLR: state_next = ntms_pkg::S_CNT;
      ntms_pkg::S_CNT: begin
        if (th_idx == ntms_pkg::TH_LAST) state_next = ntms_pkg::S_PICK;
      end
      ntms_pkg::S_PICK: begin
        if (nb_idx == ntms_pkg::NB_LAST) state_next = ntms_pkg::S_RELAY_RD;
      end
      ntms_pkg::S_RELAY_RD: begin
        state_next = best_ok ? ntms_pkg::S_RELAY_EMIT : ntms_pkg::S_FINISH;
      end
      ntms_pkg::S_RELAY_EMIT: begin
        if (out_free) state_next = ntms_pkg::S_CNT_CLR;
      end
      ntms_pkg::S_FINISH: begin
        if (out_free) state_next = ntms_pkg::S_IDLE;
      end
      default: state_next = ntms_pkg::S_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    s_tready = 1'b0;
    nb_we    = 1'b0;
    nb_re    = 1'b0;
    th_we    = 1'b0;
    th_re    = 1'b0;
    nb_waddr = nb_free;
    th_waddr = th_free;
    nb_raddr = nb_idx;
    th_raddr = th_idx;
    unique case (state)
      ntms_pkg::S_IDLE: s_tready = 1'b1;
      ntms_pkg::S_NB_RD, ntms_pkg::S_OWN_N_RD: nb_re = 1'b1;
      ntms_pkg::S_TH_RD, ntms_pkg::S_OWN_T_RD: th_re = 1'b1;
      ntms_pkg::S_DECIDE: begin
        nb_we = (phase == ntms_pkg::PH_ADD1) && !found && nb_free_ok;
        th_we = (phase == ntms_pkg::PH_ADD2_HOP) && found && th_free_ok;
      end
      ntms_pkg::S_RELAY_RD: begin
        nb_re    = best_ok;
        nb_raddr = best_idx;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ntms_pkg::S_IDLE;
      nb_valid   <= '0;
      th_valid   <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ntms_pkg::S_RELAY_EMIT || state == ntms_pkg::S_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ntms_pkg::S_DECIDE: begin
          unique case (phase)
            ntms_pkg::PH_ADD1:
              if (!found && nb_free_ok) nb_valid[nb_free] <= 1'b1;
            ntms_pkg::PH_DEL1:
              if (found) nb_valid[found_nb] <= 1'b0;
            ntms_pkg::PH_ADD2_HOP:
              if (found && th_free_ok) th_valid[th_free] <= 1'b1;
            ntms_pkg::PH_DEL2:
              if (found) th_valid[found_th] <= 1'b0;
            default: ;
          endcase
        end
        ntms_pkg::S_STATUS: pend_valid <= 1'b1;
        ntms_pkg::S_FINISH: begin
          if (out_free) pend_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ntms_pkg::S_IDLE: begin
        if (s_tvalid) begin
          kind_q   <= ntms_pkg::kind_t'(s_tuser);
          dest_q   <= {s_tdata[63:0], s_tdata[127:64]};
          hop_q    <= {s_tdata[191:128], s_tdata[255:192]};
          metric_q <= s_tdata[263:256];
        end
      end
      ntms_pkg::S_DISPATCH: begin
        nb_idx   <= '0;
        th_idx   <= '0;
        status_q <= ntms_pkg::ST_BAD_METRIC;
        unique case (kind_q)
          ntms_pkg::KIND_ADD1: phase <= ntms_pkg::PH_ADD1;
          ntms_pkg::KIND_ADD2: phase <= ntms_pkg::PH_ADD2_DUP;
          ntms_pkg::KIND_DEL1: phase <= ntms_pkg::PH_DEL1;
          ntms_pkg::KIND_DEL2: phase <= ntms_pkg::PH_DEL2;
          default:             phase <= ntms_pkg::PH_ADD1;
        endcase
      end
      ntms_pkg::S_NB_CMP: begin
        found    <= nb_hit;
        found_nb <= nb_idx;
        if (!nb_hit && nb_idx != ntms_pkg::NB_LAST) nb_idx <= nb_idx + 1'b1;
      end
      ntms_pkg::S_TH_CMP: begin
        found    <= th_hit;
        found_th <= th_idx;
        if (!th_hit && th_idx != ntms_pkg::TH_LAST) th_idx <= th_idx + 1'b1;
      end
      ntms_pkg::S_DECIDE: begin
        nb_idx <= '0;
        unique case (phase)
          ntms_pkg::PH_ADD1:
            status_q <= found ? ntms_pkg::ST_EXISTS :
                        nb_free_ok ? ntms_pkg::ST_OK : ntms_pkg::ST_FULL;
          ntms_pkg::PH_DEL1, ntms_pkg::PH_DEL2:
            status_q <= found ? ntms_pkg::ST_OK : ntms_pkg::ST_NOT_FOUND;
          ntms_pkg::PH_ADD2_DUP: begin
            status_q <= ntms_pkg::ST_EXISTS;
            phase    <= ntms_pkg::PH_ADD2_DEST;
          end
          ntms_pkg::PH_ADD2_DEST: begin
            status_q <= ntms_pkg::ST_DEST_NEIGHBOR;
            phase    <= ntms_pkg::PH_ADD2_HOP;
          end
          ntms_pkg::PH_ADD2_HOP:
            status_q <= !found ? ntms_pkg::ST_NO_NEXT_HOP :
                        th_free_ok ? ntms_pkg::ST_OK : ntms_pkg::ST_FULL;
          default: status_q <= ntms_pkg::ST_NOT_FOUND;
        endcase
      end
      ntms_pkg::S_STATUS: begin
        pend_status <= status_q;
        pend_rv     <= 1'b0;
        pend_addr   <= '0;
        own_ok      <= '0;
        covered     <= '0;
        taken       <= '0;
        nb_idx      <= '0;
      end
      ntms_pkg::S_OWN_N_RD: th_idx <= '0;
      ntms_pkg::S_OWN_T_CMP: begin
        // neighbour addresses are unique, so at most one owner per entry
        if (own_hit) begin
          own[th_idx]    <= nb_idx;
          own_ok[th_idx] <= 1'b1;
        end
        if (th_idx != ntms_pkg::TH_LAST) th_idx <= th_idx + 1'b1;
        else if (nb_idx != ntms_pkg::NB_LAST) nb_idx <= nb_idx + 1'b1;
      end
      ntms_pkg::S_CNT_CLR: begin
        for (int i = 0; i < NB_N; i++) cnt[i] <= '0;
        th_idx   <= '0;
        nb_idx   <= '0;
        best_ok  <= 1'b0;
        best_cnt <= '0;
      end
      ntms_pkg::S_CNT: begin
        if (th_valid[th_idx] && !covered[th_idx] && own_ok[th_idx])
          cnt[own[th_idx]] <= cnt[own[th_idx]] + 1'b1;
        if (th_idx != ntms_pkg::TH_LAST) th_idx <= th_idx + 1'b1;
      end
      ntms_pkg::S_PICK: begin
        // strict compare keeps the lowest slot on a tie
        if (nb_valid[nb_idx] && !taken[nb_idx] && cnt[nb_idx] > best_cnt) begin
          best_cnt <= cnt[nb_idx];
          best_idx <= nb_idx;
          best_ok  <= 1'b1;
        end
        if (nb_idx != ntms_pkg::NB_LAST) nb_idx <= nb_idx + 1'b1;
      end
      ntms_pkg::S_RELAY_RD: begin
        if (best_ok) begin
          taken[best_idx] <= 1'b1;
          for (int t = 0; t < TH_N; t++)
            if (th_valid[t] && own_ok[t] && own[t] == best_idx) covered[t] <= 1'b1;
        end
      end
      ntms_pkg::S_RELAY_EMIT: begin
        if (out_free) begin
          m_tdata     <= {5'd0, pend_addr[63:0], pend_addr[127:64], pend_status};
          m_tuser     <= pend_rv;
          m_tlast     <= 1'b0;
          pend_status <= ntms_pkg::ST_OK;
          pend_rv     <= 1'b1;
          pend_addr   <= nb_rd;
        end
      end
      ntms_pkg::S_FINISH: begin
        if (out_free) begin
          m_tdata <= {5'd0, pend_addr[63:0], pend_addr[127:64], pend_status};
          m_tuser <= pend_rv;
          m_tlast <= 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid) else $error("input taken with a result still held");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second item taken while busy");

  a_relay_status_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[2:0] == 3'(ntms_pkg::ST_OK))
    else $error("relay item with non-ok status");

  a_failure_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != 3'(ntms_pkg::ST_OK) |-> m_tlast)
    else $error("failed item followed by relays");
`endif

endmodule

// ===== hw/rtl/ntms_ram.sv =====
module ntms_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== verif/neighbor_table_mpr_select_top_tb.sv =====
`timescale 1ns / 100ps

module neighbor_table_mpr_select_top_tb;

  typedef struct {
    ntms_pkg::kind_t kind;
    logic [127:0]    dest;
    logic [127:0]    hop;
    logic [7:0]      metric;
  } event_t;

  typedef struct {
    ntms_pkg::status_t status;
    bit                relay_valid;
    logic [127:0]      relay;
    bit                last;
  } outcome_t;

  typedef struct {
    event_t            ev;
    bit                pinned;
    ntms_pkg::status_t pinned_status;
  } row_t;

  localparam int NB_N = ntms_pkg::NB_N;
  localparam int TH_N = ntms_pkg::TH_N;
  localparam int NB_POOL = 20;
  localparam int TH_POOL = 40;
  localparam int STALL_LIMIT = 50000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [263:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;

  // own copy of the neighbour and two-hop tables
  logic [127:0] nb_addr [NB_N];
  bit           nb_used [NB_N];
  logic [127:0] th_dest [TH_N];
  logic [127:0] th_next [TH_N];
  bit           th_used [TH_N];

  outcome_t     relay_runs_q[$];
  row_t         rows[$];
  logic [127:0] nb_pool [NB_POOL];
  logic [127:0] th_pool [TH_POOL];

  int src_idle = 0;
  int sink_idle = 0;
  int hold_cycles = 0;
  int errors = 0;
  int quiet_cycles = 0;

  neighbor_table_mpr_select_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int find_neighbour(logic [127:0] a);
    for (int i = 0; i < NB_N; i++)
      if (nb_used[i] && nb_addr[i] == a)
        return i;
    return -1;
  endfunction

  function automatic int count_via(int n, bit cov[TH_N]);
    int cnt;
    cnt = 0;
    for (int t = 0; t < TH_N; t++)
      if (th_used[t] && !cov[t] && th_next[t] == nb_addr[n])
        cnt++;
    return cnt;
  endfunction

  // updates the tables and queues the run of results the item should cause
  task automatic apply_event(input event_t ev, input bit pinned,
                             input ntms_pkg::status_t pinned_st);
    ntms_pkg::status_t st;
    int       slot;
    bit       dup;
    bit       cov[TH_N];
    bit       taken[NB_N];
    int       best, best_cnt, cnt;
    outcome_t r;
    st = ntms_pkg::ST_OK;
    slot = -1;
    dup = 0;
    case (ev.kind)
      ntms_pkg::KIND_ADD1: begin
        if (ev.metric != ntms_pkg::METRIC_ONE_HOP) st = ntms_pkg::ST_BAD_METRIC;
        else if (find_neighbour(ev.dest) >= 0) st = ntms_pkg::ST_EXISTS;
        else begin
          for (int i = 0; i < NB_N && slot < 0; i++)
            if (!nb_used[i]) slot = i;
          if (slot < 0) st = ntms_pkg::ST_FULL;
          else begin
            nb_addr[slot] = ev.dest;
            nb_used[slot] = 1;
          end
        end
      end
      ntms_pkg::KIND_ADD2: begin
        for (int i = 0; i < TH_N; i++)
          if (th_used[i] && th_dest[i] == ev.dest) dup = 1;
        if (ev.metric != ntms_pkg::METRIC_TWO_HOP) st = ntms_pkg::ST_BAD_METRIC;
        else if (dup) st = ntms_pkg::ST_EXISTS;
        else if (find_neighbour(ev.dest) >= 0) st = ntms_pkg::ST_DEST_NEIGHBOR;
        else if (find_neighbour(ev.hop) < 0) st = ntms_pkg::ST_NO_NEXT_HOP;
        else begin
          for (int i = 0; i < TH_N && slot < 0; i++)
            if (!th_used[i]) slot = i;
          if (slot < 0) st = ntms_pkg::ST_FULL;
          else begin
            th_dest[slot] = ev.dest;
            th_next[slot] = ev.hop;
            th_used[slot] = 1;
          end
        end
      end
      ntms_pkg::KIND_DEL1: begin
        slot = find_neighbour(ev.dest);
        if (slot < 0) st = ntms_pkg::ST_NOT_FOUND;
        else nb_used[slot] = 0;
      end
      default: begin
        for (int i = 0; i < TH_N && slot < 0; i++)
          if (th_used[i] && th_dest[i] == ev.dest && th_next[i] == ev.hop) slot = i;
        if (slot < 0) st = ntms_pkg::ST_NOT_FOUND;
        else th_used[slot] = 0;
      end
    endcase
    r.status = pinned ? pinned_st : st;
    r.relay_valid = 0;
    r.relay = '0;
    r.last = 0;
    relay_runs_q = {relay_runs_q, r};
    if (st == ntms_pkg::ST_OK) begin
      foreach (cov[t]) cov[t] = 0;
      foreach (taken[n]) taken[n] = 0;
      for (int round = 0; round < NB_N; round++) begin
        best = -1;
        best_cnt = 0;
        for (int n = 0; n < NB_N; n++) begin
          if (nb_used[n] && !taken[n]) begin
            cnt = count_via(n, cov);
            if (cnt > best_cnt) begin
              best_cnt = cnt;
              best = n;
            end
          end
        end
        if (best < 0) break;
        taken[best] = 1;
        for (int t = 0; t < TH_N; t++)
          if (th_used[t] && th_next[t] == nb_addr[best]) cov[t] = 1;
        r.status = ntms_pkg::ST_OK;
        r.relay_valid = 1;
        r.relay = nb_addr[best];
        relay_runs_q = {relay_runs_q, r};
      end
    end
    relay_runs_q[relay_runs_q.size() - 1].last = 1;
  endtask

  task automatic send_event(input event_t ev, input bit pinned,
                            input ntms_pkg::status_t pinned_st);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = ev.kind;
    s_tdata  = {ev.metric, ev.hop[63:0], ev.hop[127:64], ev.dest[63:0], ev.dest[127:64]};
    do @(posedge clk); while (!s_tready);
    apply_event(ev, pinned, pinned_st);
    @(negedge clk);
  endtask

  function automatic row_t row(ntms_pkg::kind_t k, logic [127:0] d, logic [127:0] h,
                               logic [7:0] m, bit pinned = 0,
                               ntms_pkg::status_t st = ntms_pkg::ST_OK);
    row_t r;
    r.ev.kind = k;
    r.ev.dest = d;
    r.ev.hop = h;
    r.ev.metric = m;
    r.pinned = pinned;
    r.pinned_status = st;
    return r;
  endfunction

  function automatic logic [127:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // mostly well-formed events over small address pools so tables fill and hit
  function automatic event_t random_event();
    event_t ev;
    int     pick, n;
    ev.metric = 8'($urandom_range(255));
    ev.hop = nb_pool[$urandom_range(NB_POOL - 1)];
    pick = $urandom_range(99);
    if (pick < 8) begin
      ev.kind = ntms_pkg::kind_t'($urandom_range(3));
      ev.dest = rand_addr();
      ev.hop = rand_addr();
      return ev;
    end
    if (pick < 35) begin
      ev.kind = ntms_pkg::KIND_ADD1;
      ev.dest = nb_pool[$urandom_range(NB_POOL - 1)];
      if ($urandom_range(9) != 0) ev.metric = ntms_pkg::METRIC_ONE_HOP;
    end else if (pick < 80) begin
      ev.kind = ntms_pkg::KIND_ADD2;
      ev.dest = ($urandom_range(19) == 0) ? nb_pool[$urandom_range(NB_POOL - 1)]
                                          : th_pool[$urandom_range(TH_POOL - 1)];
      if ($urandom_range(4) != 0) begin
        n = $urandom_range(NB_N - 1);
        if (nb_used[n]) ev.hop = nb_addr[n];
      end
      if ($urandom_range(9) != 0) ev.metric = ntms_pkg::METRIC_TWO_HOP;
    end else if (pick < 88) begin
      ev.kind = ntms_pkg::KIND_DEL1;
      ev.dest = nb_pool[$urandom_range(NB_POOL - 1)];
    end else begin
      ev.kind = ntms_pkg::KIND_DEL2;
      ev.dest = th_pool[$urandom_range(TH_POOL - 1)];
      n = $urandom_range(TH_N - 1);
      if (th_used[n] && $urandom_range(3) != 0) begin
        ev.dest = th_dest[n];
        ev.hop = th_next[n];
      end
    end
    return ev;
  endfunction

  // sink side ready, with the long hold-off counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("** neighbor_table_mpr_select_top: FAILED **");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (relay_runs_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d relay=%h last=%b", $time,
                   m_tdata[2:0], {m_tdata[66:3], m_tdata[130:67]}, m_tlast);
        end else begin
          want = relay_runs_q.pop_front();
          if (m_tdata[2:0] != want.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.status, m_tdata[2:0]);
          end
          if (m_tuser[0] != want.relay_valid) begin
            errors++;
            $display("%0t: relay_valid expected %b got %b", $time, want.relay_valid,
                     m_tuser[0]);
          end
          if (m_tdata[66:3] != want.relay[127:64]) begin
            errors++;
            $display("%0t: relay_hi expected %h got %h", $time, want.relay[127:64],
                     m_tdata[66:3]);
          end
          if (m_tdata[130:67] != want.relay[63:0]) begin
            errors++;
            $display("%0t: relay_lo expected %h got %h", $time, want.relay[63:0],
                     m_tdata[130:67]);
          end
          if (m_tlast != want.last) begin
            errors++;
            $display("%0t: last expected %b got %b", $time, want.last, m_tlast);
          end
        end
      end
    end
  end

  initial begin
    logic [127:0] a_ones, b_zero, c_mix, d1, d2, d3, d4;
    a_ones = '1;
    b_zero = '0;
    c_mix  = 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;
    d1 = 128'h8000_0000_0000_0001_0000_0000_0000_0001;
    d2 = 128'h5555_5555_5555_5555_aaaa_aaaa_aaaa_aaaa;
    d3 = 128'haaaa_aaaa_aaaa_aaaa_5555_5555_5555_5555;
    d4 = 128'h7fff_ffff_ffff_ffff_ffff_ffff_ffff_fffe;
    foreach (nb_used[i]) nb_used[i] = 0;
    foreach (th_used[i]) th_used[i] = 0;
    foreach (nb_pool[i]) nb_pool[i] = rand_addr();
    foreach (th_pool[i]) th_pool[i] = rand_addr();
    nb_pool[0] = a_ones;
    nb_pool[1] = b_zero;
    th_pool[0] = d1;

    rows = {rows, row(ntms_pkg::KIND_DEL1, a_ones, b_zero, 8'd1, 1,
                      ntms_pkg::ST_NOT_FOUND)};
    rows = {rows, row(ntms_pkg::KIND_DEL2, d1, a_ones, 8'd255, 1,
                      ntms_pkg::ST_NOT_FOUND)};
    rows = {rows, row(ntms_pkg::KIND_ADD1, a_ones, b_zero, 8'd0, 1,
                      ntms_pkg::ST_BAD_METRIC)};
    rows = {rows, row(ntms_pkg::KIND_ADD1, a_ones, b_zero, 8'd255, 1,
                      ntms_pkg::ST_BAD_METRIC)};
    rows = {rows, row(ntms_pkg::KIND_ADD1, a_ones, b_zero, ntms_pkg::METRIC_ONE_HOP, 1,
                      ntms_pkg::ST_OK)};
    rows = {rows, row(ntms_pkg::KIND_ADD1, a_ones, b_zero, ntms_pkg::METRIC_ONE_HOP, 1,
                      ntms_pkg::ST_EXISTS)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, a_ones, a_ones, ntms_pkg::METRIC_TWO_HOP, 1,
                      ntms_pkg::ST_DEST_NEIGHBOR)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, d1, b_zero, ntms_pkg::METRIC_TWO_HOP, 1,
                      ntms_pkg::ST_NO_NEXT_HOP)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, d1, a_ones, ntms_pkg::METRIC_ONE_HOP, 1,
                      ntms_pkg::ST_BAD_METRIC)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, d1, a_ones, ntms_pkg::METRIC_TWO_HOP, 1,
                      ntms_pkg::ST_OK)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, d1, a_ones, ntms_pkg::METRIC_TWO_HOP, 1,
                      ntms_pkg::ST_EXISTS)};
    rows = {rows, row(ntms_pkg::KIND_ADD1, b_zero, a_ones, ntms_pkg::METRIC_ONE_HOP)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, d2, b_zero, ntms_pkg::METRIC_TWO_HOP)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, d3, b_zero, ntms_pkg::METRIC_TWO_HOP)};
    rows = {rows, row(ntms_pkg::KIND_ADD1, c_mix, b_zero, ntms_pkg::METRIC_ONE_HOP)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, d4, c_mix, ntms_pkg::METRIC_TWO_HOP)};
    // orphaned two-hop entry stays in the table with no cover
    rows = {rows, row(ntms_pkg::KIND_DEL1, a_ones, d1, 8'd7)};
    rows = {rows, row(ntms_pkg::KIND_ADD2, d2, c_mix, ntms_pkg::METRIC_TWO_HOP)};
    rows = {rows, row(ntms_pkg::KIND_DEL2, d2, c_mix, 8'd0, 1, ntms_pkg::ST_NOT_FOUND)};
    rows = {rows, row(ntms_pkg::KIND_ADD1, a_ones, b_zero, ntms_pkg::METRIC_ONE_HOP)};
    rows = {rows, row(ntms_pkg::KIND_DEL2, d1, a_ones, 8'd0)};
    rows = {rows, row(ntms_pkg::KIND_DEL2, d4, c_mix, 8'd0)};
    rows = {rows, row(ntms_pkg::KIND_DEL1, b_zero, b_zero, 8'd0)};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle = 14;
    sink_idle = 58;
    foreach (rows[i]) send_event(rows[i].ev, rows[i].pinned, rows[i].pinned_status);
    for (int phase = 0; phase < 3; phase++) begin
      src_idle  = (phase == 0) ? 14 : (phase == 1) ? 58 : 0;
      sink_idle = (phase == 0) ? 58 : (phase == 1) ? 14 : 0;
      if (phase == 2) hold_cycles = 3000;
      for (int i = 0; i < 26; i++) send_event(random_event(), 0, ntms_pkg::ST_OK);
      s_tvalid = 1'b0;
      // sender pauses until the whole backlog has drained
      while (relay_runs_q.size() != 0) @(negedge clk);
    end

    s_tvalid = 1'b0;
    while (relay_runs_q.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("** neighbor_table_mpr_select_top: PASSED **");
    end else begin
      $display("** neighbor_table_mpr_select_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ntms_pkg.sv
hw/rtl/ntms_ram.sv
hw/rtl/neighbor_table_mpr_select_top.sv
verif/neighbor_table_mpr_select_top_tb.sv
